### hdl/uv_histogram_field_color_learner_macros.svh
// ----------------------------------------------------------------------------
// uv histogram field colour learner assertion macros
// concurrent assertion shorthands shared by the learner rtl
// ----------------------------------------------------------------------------
`ifndef UV_HISTOGRAM_FIELD_COLOR_LEARNER_MACROS_SVH
`define UV_HISTOGRAM_FIELD_COLOR_LEARNER_MACROS_SVH

// same-cycle implication, disabled during reset
`define UVH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define UVH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/uvh_pkg.sv
// ----------------------------------------------------------------------------
// uvh_pkg
// beat types, control struct, state codes and fixed constants of the learner
// ----------------------------------------------------------------------------
package uvh_pkg;

    localparam int CHROMA_W   = 8;
    localparam int THR_W      = 7;
    localparam int PCT_SCALE  = 100;
    localparam int MAX_BIN_W  = 8;   // up to 256 bins
    localparam int MAX_RING_W = 12;  // up to 16 frames of 256 bins

    localparam logic [THR_W-1:0] THR_RESET = 7'd30;

    typedef struct packed {
        logic                req_type;
        logic [CHROMA_W-1:0] u_value;
        logic [CHROMA_W-1:0] v_value;
        logic                in_mask;
        logic                frame_end;
    } uvh_pix_t;

    typedef struct packed {
        logic is_green;
        logic field_formed;
    } uvh_res_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_PUSH,
        ST_SCALE,
        ST_MAP
    } uvh_state_t;

    // bin walk control, top level to channel
    typedef struct packed {
        logic                  clr_wr;
        logic                  push_rd;
        logic                  push_wr;
        logic                  map_rd;
        logic                  map_wr;
        logic                  max_clr;
        logic                  scale;
        logic                  full;
        logic [MAX_BIN_W-1:0]  rd_idx;
        logic [MAX_BIN_W-1:0]  wr_idx;
        logic [MAX_RING_W-1:0] ring_base;
        logic [THR_W-1:0]      thr;
    } uvh_ctl_t;

endpackage

### hdl/uv_histogram_field_color_learner.sv
// pixel or query beat: result via stage one and result register, one beat per cycle
// unless a walk or res_stall holds it; a frame_end pixel holds its result for a bin
// walk, and once the window is full for a scale step and a walk that rebuilds the
// field maps; no beat taken meanwhile; rate is set by the single read port of each
// frame count memory; after reset clearing zeroes counts and sums, pixels stalled
// ----------------------------------------------------------------------------
// uv_histogram_field_color_learner
// sliding window chroma histogram with percent threshold field colour maps
// ----------------------------------------------------------------------------
`include "uv_histogram_field_color_learner_macros.svh"

module uv_histogram_field_color_learner
    import uvh_pkg::*;
#(
    parameter int BINS          = 32,
    parameter int WINDOW_FRAMES = 5,
    parameter int COUNT_BITS    = 19
)
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration write channel: threshold percent
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [THR_W-1:0] cfg_data,
    // pixel and query beats
    input  logic             pix_valid,
    output logic             pix_stall,
    input  uvh_pix_t         pix_data,
    // result beats
    output logic             res_valid,
    input  logic             res_stall,
    output uvh_res_t         res_data
);

    localparam int BIN_W  = $clog2(BINS);
    localparam int IDX_W  = $clog2(BINS + 1);
    localparam int HELD_W = $clog2(WINDOW_FRAMES + 1);
    localparam int RING_W = $clog2(WINDOW_FRAMES * BINS);
    localparam int PROD_W = CHROMA_W + BIN_W + 1;

    // control state
    uvh_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [HELD_W-1:0] frames_held_reg, frames_held_next;
    logic [RING_W-1:0] ring_base_reg, ring_base_next;
    logic              formed_reg, formed_next;
    logic [THR_W-1:0]  thr_reg;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_first_reg;
    logic              s1_close_reg, s1_close_next;
    logic              res_valid_reg, res_valid_next;

    // payload
    logic              s1_query_reg;
    logic              s1_mask_reg;
    uvh_res_t          res_data_reg;

    logic              pix_acc;
    logic              s1_go;
    logic              commit;
    logic              walk_start;
    logic              walk_done;
    logic              idx_last;
    logic              window_full;
    logic [HELD_W-1:0] held_inc;
    logic              forming;
    logic [PROD_W-1:0] u_prod;
    logic [PROD_W-1:0] v_prod;
    logic [BIN_W-1:0]  u_bin;
    logic [BIN_W-1:0]  v_bin;
    logic              map_u;
    logic              map_v;
    uvh_ctl_t          ctl;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    // stage one leaves once its result register slot is free; a frame
    // closing beat waits for the end of its bin walk
    assign s1_go     = s1_valid_reg && !s1_close_reg && (!res_valid_reg || !res_stall);
    assign pix_stall = (state_reg != ST_RUN) || (s1_valid_reg && !s1_go);
    assign pix_acc   = pix_valid && !pix_stall;

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // bin of a chroma value: (value * BINS) >> 8
    always_comb
    begin
        u_prod = PROD_W'(pix_data.u_value) * PROD_W'(BINS);
        v_prod = PROD_W'(pix_data.v_value) * PROD_W'(BINS);
        u_bin  = u_prod[CHROMA_W +: BIN_W];
        v_bin  = v_prod[CHROMA_W +: BIN_W];
    end

    // ------------------------------------------------------------------
    // walk bookkeeping
    // ------------------------------------------------------------------
    always_comb
    begin
        // count lands on the first cycle of a masked pixel in stage one
        commit      = s1_valid_reg && s1_first_reg && !s1_query_reg && s1_mask_reg;
        walk_start  = s1_valid_reg && s1_first_reg && s1_close_reg;
        idx_last    = (idx_reg == IDX_W'(BINS));
        window_full = (frames_held_reg >= HELD_W'(WINDOW_FRAMES));
        held_inc    = window_full ? frames_held_reg : frames_held_reg + HELD_W'(1);
        forming     = (held_inc >= HELD_W'(WINDOW_FRAMES));
        walk_done   = ((state_reg == ST_PUSH) && idx_last && !forming)
                    || ((state_reg == ST_MAP) && idx_last);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (idx_reg == IDX_W'(BINS - 1))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (walk_start)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (idx_last)
                begin
                    state_next = forming ? ST_SCALE : ST_RUN;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_MAP;
            end
            ST_MAP:
            begin
                if (idx_last)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // walk control outputs
    always_comb
    begin
        ctl           = '0;
        ctl.full      = window_full;
        ctl.thr       = thr_reg;
        ctl.ring_base = MAX_RING_W'(ring_base_reg);
        case (state_reg)
            ST_CLEAR:
            begin
                // zero frame counts and window sums
                ctl.clr_wr = 1'b1;
                ctl.wr_idx = MAX_BIN_W'(idx_reg[BIN_W-1:0]);
            end
            ST_PUSH:
            begin
                // read bin i, write it back in the cycle after
                ctl.push_rd = !idx_last;
                ctl.push_wr = (idx_reg != '0);
                ctl.max_clr = (idx_reg == '0);
                ctl.rd_idx  = MAX_BIN_W'(idx_reg[BIN_W-1:0]);
                ctl.wr_idx  = MAX_BIN_W'(BIN_W'(idx_reg - IDX_W'(1)));
            end
            ST_SCALE:
            begin
                ctl.scale = 1'b1;
            end
            ST_MAP:
            begin
                ctl.map_rd = !idx_last;
                ctl.map_wr = (idx_reg != '0);
                ctl.rd_idx = MAX_BIN_W'(idx_reg[BIN_W-1:0]);
                ctl.wr_idx = MAX_BIN_W'(BIN_W'(idx_reg - IDX_W'(1)));
            end
            default:
            begin
                ctl.clr_wr = 1'b0;
            end
        endcase
    end

    // counters, window bookkeeping and the stage one / result pipeline
    always_comb
    begin
        idx_next = '0;
        if ((state_next == state_reg) &&
            ((state_reg == ST_CLEAR) || (state_reg == ST_PUSH) || (state_reg == ST_MAP)))
        begin
            idx_next = idx_reg + IDX_W'(1);
        end

        frames_held_next = frames_held_reg;
        ring_base_next   = ring_base_reg;
        if ((state_reg == ST_PUSH) && idx_last)
        begin
            frames_held_next = held_inc;
            if (ring_base_reg == RING_W'((WINDOW_FRAMES - 1) * BINS))
            begin
                ring_base_next = '0;
            end
            else
            begin
                ring_base_next = ring_base_reg + RING_W'(BINS);
            end
        end

        formed_next = formed_reg || ((state_reg == ST_MAP) && idx_last);

        if (pix_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (pix_acc)
        begin
            s1_close_next = !pix_data.req_type && pix_data.frame_end;
        end
        else if (walk_done)
        begin
            s1_close_next = 1'b0;
        end
        else
        begin
            s1_close_next = s1_close_reg;
        end

        if (s1_go)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            idx_reg         <= '0;
            frames_held_reg <= '0;
            ring_base_reg   <= '0;
            formed_reg      <= 1'b0;
            thr_reg         <= THR_RESET;
            s1_valid_reg    <= 1'b0;
            s1_first_reg    <= 1'b0;
            s1_close_reg    <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            idx_reg         <= idx_next;
            frames_held_reg <= frames_held_next;
            ring_base_reg   <= ring_base_next;
            formed_reg      <= formed_next;
            s1_valid_reg    <= s1_valid_next;
            s1_first_reg    <= pix_acc;
            s1_close_reg    <= s1_close_next;
            res_valid_reg   <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_query_reg <= pix_data.req_type;
            s1_mask_reg  <= pix_data.in_mask;
        end
        if (s1_go)
        begin
            // maps hold no meaning until the first window has formed
            res_data_reg.is_green     <= s1_query_reg && formed_reg && map_u && map_v;
            res_data_reg.field_formed <= formed_reg;
        end
    end

    // ------------------------------------------------------------------
    // channels
    // ------------------------------------------------------------------
    uvh_chan #(
        .BINS          (BINS),
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_chan_u (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .acc     (pix_acc),
        .acc_bin (u_bin),
        .commit  (commit),
        .map_bit (map_u)
    );

    uvh_chan #(
        .BINS          (BINS),
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_chan_v (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .acc     (pix_acc),
        .acc_bin (v_bin),
        .commit  (commit),
        .map_bit (map_v)
    );

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `UVH_ASSERT_IMPL(a_close_waits, clk, rst_n, s1_valid_reg && s1_close_reg, !s1_go,
                     "frame closing beat left before its bin walk")
    `UVH_ASSERT_IMPL(a_accept_run, clk, rst_n, pix_acc,
                     (state_reg == ST_RUN) && (!s1_valid_reg || s1_go),
                     "beat accepted during walk or over a held stage")
    `UVH_ASSERT_NEXT(a_formed_sticky, clk, rst_n, formed_reg, formed_reg,
                     "field formed flag dropped")
    `UVH_ASSERT_IMPL(a_held_range, clk, rst_n, 1'b1,
                     frames_held_reg <= HELD_W'(WINDOW_FRAMES),
                     "frames held beyond window")

endmodule

### hdl/uvh_chan.sv
// ----------------------------------------------------------------------------
// uvh_chan
// one chroma channel: frame counts, frame ring, window sums and field map
// ----------------------------------------------------------------------------
module uvh_chan
    import uvh_pkg::*;
#(
    parameter int BINS          = 32,
    parameter int WINDOW_FRAMES = 5,
    parameter int COUNT_BITS    = 19
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  uvh_ctl_t                ctl,
    input  logic                    acc,
    input  logic [$clog2(BINS)-1:0] acc_bin,
    input  logic                    commit,
    output logic                    map_bit
);

    localparam int BIN_W      = $clog2(BINS);
    localparam int RING_DEPTH = WINDOW_FRAMES * BINS;
    localparam int RING_W     = $clog2(RING_DEPTH);
    localparam int SUM_W      = COUNT_BITS + $clog2(WINDOW_FRAMES);
    localparam int LIM_W      = SUM_W + THR_W;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] fc_mem   [BINS];
    logic [COUNT_BITS-1:0] ring_mem [RING_DEPTH];
    logic [SUM_W-1:0]      sum_mem  [BINS];
    logic                  map_mem  [BINS];

    logic [COUNT_BITS-1:0] fc_rd_reg;
    logic [COUNT_BITS-1:0] ring_rd_reg;
    logic [SUM_W-1:0]      sum_rd_reg;
    logic                  map_rd_reg;
    logic [BIN_W-1:0]      s1_bin_reg;
    logic                  fwd_hit_reg;
    logic [COUNT_BITS-1:0] fwd_val_reg;
    logic [SUM_W-1:0]      max_reg;
    logic [LIM_W-1:0]      lim_reg;

    logic [BIN_W-1:0]      rd_idx;
    logic [BIN_W-1:0]      wr_idx;
    logic [RING_W-1:0]     ring_rd_addr;
    logic [RING_W-1:0]     ring_wr_addr;
    logic [COUNT_BITS-1:0] cur;
    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] leaving;
    logic [SUM_W-1:0]      new_sum;
    logic                  fc_we;
    logic [BIN_W-1:0]      fc_wa;
    logic [COUNT_BITS-1:0] fc_wd;
    logic                  fc_re;
    logic [BIN_W-1:0]      fc_ra;
    logic                  keep;

    always_comb
    begin
        rd_idx       = ctl.rd_idx[BIN_W-1:0];
        wr_idx       = ctl.wr_idx[BIN_W-1:0];
        ring_rd_addr = ctl.ring_base[RING_W-1:0] + RING_W'(rd_idx);
        ring_wr_addr = ctl.ring_base[RING_W-1:0] + RING_W'(wr_idx);

        // saturating count with bypass of a write landing in the same cycle as the read
        cur = fwd_hit_reg ? fwd_val_reg : fc_rd_reg;
        inc = (cur == COUNT_MAX) ? cur : cur + COUNT_BITS'(1);

        leaving = ctl.full ? ring_rd_reg : '0;
        new_sum = sum_rd_reg - SUM_W'(leaving) + SUM_W'(fc_rd_reg);

        fc_we = ctl.clr_wr | ctl.push_wr | commit;
        fc_wa = commit ? s1_bin_reg : wr_idx;
        fc_wd = commit ? inc : '0;
        fc_re = acc | ctl.push_rd;
        fc_ra = acc ? acc_bin : rd_idx;

        keep = (LIM_W'(sum_rd_reg) * LIM_W'(PCT_SCALE)) >= lim_reg;
    end

    // frame count memory
    always_ff @(posedge clk)
    begin
        if (fc_we)
        begin
            fc_mem[fc_wa] <= fc_wd;
        end
        if (fc_re)
        begin
            fc_rd_reg <= fc_mem[fc_ra];
        end
    end

    // frame ring memory
    always_ff @(posedge clk)
    begin
        if (ctl.push_wr)
        begin
            ring_mem[ring_wr_addr] <= fc_rd_reg;
        end
        if (ctl.push_rd)
        begin
            ring_rd_reg <= ring_mem[ring_rd_addr];
        end
    end

    // window sum memory
    always_ff @(posedge clk)
    begin
        if (ctl.clr_wr | ctl.push_wr)
        begin
            sum_mem[wr_idx] <= ctl.clr_wr ? '0 : new_sum;
        end
        if (ctl.push_rd | ctl.map_rd)
        begin
            sum_rd_reg <= sum_mem[rd_idx];
        end
    end

    // field map memory
    always_ff @(posedge clk)
    begin
        if (ctl.map_wr)
        begin
            map_mem[wr_idx] <= keep;
        end
        if (acc)
        begin
            map_rd_reg <= map_mem[acc_bin];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (acc)
        begin
            fwd_hit_reg <= commit && (s1_bin_reg == acc_bin);
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_bin_reg  <= acc_bin;
            fwd_val_reg <= inc;
        end
        if (ctl.max_clr)
        begin
            max_reg <= '0;
        end
        else if (ctl.push_wr && (new_sum > max_reg))
        begin
            max_reg <= new_sum;
        end
        if (ctl.scale)
        begin
            lim_reg <= LIM_W'(ctl.thr) * LIM_W'(max_reg);
        end
    end

    assign map_bit = map_rd_reg;

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb - uv histogram field colour learner bench
// drives pixel and query beats through the learner under random idling and
// back-pressure, takes each result beat from the directed table or predicts it from
// its own copy of the frame counts, window sums and field maps, and compares them field by field
// ----------------------------------------------------------------------------
module tb
    import uvh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS          = 32;
    localparam int WINDOW_FRAMES = 5;
    localparam int COUNT_BITS    = 19;
    localparam int SUM_W         = 22;

    localparam logic [COUNT_BITS-1:0] COUNT_TOP = {COUNT_BITS{1'b1}};

    // beat kinds carried in req_type
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // how a directed row is checked
    localparam logic PREDICT = 1'b0;
    localparam logic FIXED   = 1'b1;

    // longest bin walk plus margin, waited out before a register write and at the end
    localparam int SETTLE      = 2 * BINS + 8;
    localparam int HOLD_LEN    = 300;
    localparam int IDLE_PCT    = 6;
    localparam int DIR_N       = 23;
    localparam int TIMEOUT_NS  = 5_000_000;

    typedef struct packed {
        uvh_pix_t pix;
        logic     typed;
        uvh_res_t res;
    } dir_row_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [THR_W-1:0] cfg_data;
    logic             pix_valid;
    logic             pix_stall;
    uvh_pix_t         pix_data;
    logic             res_valid;
    logic             res_stall;
    uvh_res_t         res_data;

    // ------------------------------------------------------------------------
    // predictor state: a private copy of the learner
    // ------------------------------------------------------------------------
    logic [COUNT_BITS-1:0] cnt_u [BINS];
    logic [COUNT_BITS-1:0] cnt_v [BINS];
    logic [COUNT_BITS-1:0] ring_u [WINDOW_FRAMES][BINS];
    logic [COUNT_BITS-1:0] ring_v [WINDOW_FRAMES][BINS];
    logic [SUM_W-1:0]      wsum_u [BINS];
    logic [SUM_W-1:0]      wsum_v [BINS];
    logic                  fmap_u [BINS];
    logic                  fmap_v [BINS];
    int                    frames_in;
    int                    slot_next;
    logic                  maps_formed;
    logic [THR_W-1:0]      thr_pct;

    uvh_res_t verdict_q [$];
    dir_row_t dir_rows [DIR_N];

    int   mismatches    = 0;
    int   verdicts_seen = 0;
    int   pixels_sent   = 0;
    int   queries_sent  = 0;
    int   frames_closed = 0;
    int   pixels_to_close = 8;
    int   hold_reqs;
    logic quiet;

    uv_histogram_field_color_learner #(
        .BINS          (BINS),
        .WINDOW_FRAMES (WINDOW_FRAMES),
        .COUNT_BITS    (COUNT_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // predictor: one beat in, the result beat it causes out
    // ------------------------------------------------------------------------
    function automatic uvh_res_t predict_verdict(input uvh_pix_t p);
        int               ub;
        int               vb;
        int               b;
        logic [SUM_W-1:0] top_u;
        logic [SUM_W-1:0] top_v;
        uvh_res_t         r;
        ub = (int'(p.u_value) * BINS) >> CHROMA_W;
        vb = (int'(p.v_value) * BINS) >> CHROMA_W;
        r.is_green = 1'b0;
        if (p.req_type == REQ_QUERY)
        begin
            // queries leave every bit of state alone
            r.is_green = fmap_u[ub] && fmap_v[vb];
        end
        else
        begin
            if (p.in_mask)
            begin
                // frame counts stick at the top
                if (cnt_u[ub] != COUNT_TOP)
                    cnt_u[ub] = cnt_u[ub] + 1'b1;
                if (cnt_v[vb] != COUNT_TOP)
                    cnt_v[vb] = cnt_v[vb] + 1'b1;
            end
            if (p.frame_end)
            begin
                // push the frame into the ring, dropping the oldest once full
                for (b = 0; b < BINS; b++)
                begin
                    if (frames_in >= WINDOW_FRAMES)
                    begin
                        wsum_u[b] = wsum_u[b] - ring_u[slot_next][b];
                        wsum_v[b] = wsum_v[b] - ring_v[slot_next][b];
                    end
                    wsum_u[b] = wsum_u[b] + cnt_u[b];
                    wsum_v[b] = wsum_v[b] + cnt_v[b];
                    ring_u[slot_next][b] = cnt_u[b];
                    ring_v[slot_next][b] = cnt_v[b];
                    cnt_u[b] = '0;
                    cnt_v[b] = '0;
                end
                slot_next = (slot_next + 1) % WINDOW_FRAMES;
                if (frames_in < WINDOW_FRAMES)
                    frames_in++;
                if (frames_in >= WINDOW_FRAMES)
                begin
                    top_u = '0;
                    top_v = '0;
                    for (b = 0; b < BINS; b++)
                    begin
                        if (wsum_u[b] > top_u)
                            top_u = wsum_u[b];
                        if (wsum_v[b] > top_v)
                            top_v = wsum_v[b];
                    end
                    // percent compare, no division: an empty window marks every bin
                    for (b = 0; b < BINS; b++)
                    begin
                        fmap_u[b] = longint'(wsum_u[b]) * PCT_SCALE
                                    >= longint'(thr_pct) * longint'(top_u);
                        fmap_v[b] = longint'(wsum_v[b]) * PCT_SCALE
                                    >= longint'(thr_pct) * longint'(top_v);
                    end
                    maps_formed = 1'b1;
                end
            end
        end
        r.field_formed = maps_formed;
        return r;
    endfunction

    function automatic dir_row_t row(input logic rq, input int u, input int v,
                                     input logic m, input logic fe, input logic typed,
                                     input logic g, input logic f);
        dir_row_t r;
        r.pix.req_type     = rq;
        r.pix.u_value      = u[7:0];
        r.pix.v_value      = v[7:0];
        r.pix.in_mask      = m;
        r.pix.frame_end    = fe;
        r.typed            = typed;
        r.res.is_green     = g;
        r.res.field_formed = f;
        return r;
    endfunction

    // chroma a few codes either side of a cluster centre
    function automatic logic [CHROMA_W-1:0] near(input int c);
        int x;
        x = c + int'($urandom_range(0, 24)) - 12;
        if (x < 0)
            x = 0;
        if (x > 255)
            x = 255;
        return x[CHROMA_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    task automatic send_item(input uvh_pix_t p, input logic typed, input uvh_res_t fixed_res);
        uvh_res_t want;
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= p;
        do
            @(posedge clk);
        while (pix_stall !== 1'b0);
        // beat taken at this edge
        want = predict_verdict(p);
        if (typed)
            want = fixed_res;
        verdict_q.insert(verdict_q.size(), want);
        if (p.req_type == REQ_QUERY)
            queries_sent++;
        else
        begin
            pixels_sent++;
            if (p.frame_end)
                frames_closed++;
        end
    endtask

    // sender goes quiet until every result beat is home
    task automatic drain();
        pix_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] pct);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= pct;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        thr_pct = pct;
    endtask

    // mostly whole frames of clustered, masked pixels with queries mixed in;
    // the rest is loose pixels with random mask and early frame ends
    task automatic random_stretch(input int n, input int cu, input int cv);
        uvh_pix_t p;
        uvh_res_t none;
        int       roll;
        int       k;
        none = '0;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 28)
            begin
                p.req_type  = REQ_QUERY;
                p.u_value   = roll[0] ? near(cu) : CHROMA_W'($urandom);
                p.v_value   = roll[1] ? near(cv) : CHROMA_W'($urandom);
                p.in_mask   = 1'($urandom);
                p.frame_end = 1'($urandom);
            end
            else if (roll < 34)
            begin
                p.req_type  = REQ_PIXEL;
                p.u_value   = CHROMA_W'($urandom);
                p.v_value   = CHROMA_W'($urandom);
                p.in_mask   = 1'($urandom);
                p.frame_end = 1'($urandom);
                if (p.frame_end)
                    pixels_to_close = $urandom_range(3, 24);
            end
            else
            begin
                p.req_type = REQ_PIXEL;
                p.u_value  = ($urandom_range(0, 9) < 7) ? near(cu) : CHROMA_W'($urandom);
                p.v_value  = ($urandom_range(0, 9) < 7) ? near(cv) : CHROMA_W'($urandom);
                p.in_mask  = ($urandom_range(0, 9) != 0);
                pixels_to_close--;
                p.frame_end = (pixels_to_close <= 0);
                if (p.frame_end)
                    pixels_to_close = $urandom_range(3, 24);
            end
            send_item(p, PREDICT, none);
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int i;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        hold_reqs <= 0;
        quiet     <= 1'b0;

        // predictor after reset
        for (i = 0; i < BINS; i++)
        begin
            cnt_u[i]  = '0;
            cnt_v[i]  = '0;
            wsum_u[i] = '0;
            wsum_v[i] = '0;
            fmap_u[i] = 1'b0;
            fmap_v[i] = 1'b0;
        end
        frames_in   = 0;
        slot_next   = 0;
        maps_formed = 1'b0;
        thr_pct     = THR_RESET;

        // directed table: queries before forming, chroma extremes, bin edges,
        // ignored mask and frame end on a query, frames with nothing counted,
        // the window filling, then an empty window marking every bin
        dir_rows[0]  = row(REQ_QUERY,   0,   0, 1'b0, 1'b0, FIXED,   1'b0, 1'b0);
        dir_rows[1]  = row(REQ_QUERY, 255, 255, 1'b0, 1'b0, FIXED,   1'b0, 1'b0);
        dir_rows[2]  = row(REQ_PIXEL,   0, 255, 1'b1, 1'b0, FIXED,   1'b0, 1'b0);
        dir_rows[3]  = row(REQ_PIXEL, 255,   0, 1'b1, 1'b0, FIXED,   1'b0, 1'b0);
        dir_rows[4]  = row(REQ_PIXEL, 128, 128, 1'b0, 1'b0, FIXED,   1'b0, 1'b0);
        dir_rows[5]  = row(REQ_PIXEL,   7,   8, 1'b1, 1'b1, FIXED,   1'b0, 1'b0);
        dir_rows[6]  = row(REQ_QUERY,   7,   8, 1'b1, 1'b1, FIXED,   1'b0, 1'b0);
        dir_rows[7]  = row(REQ_PIXEL,   0,   0, 1'b0, 1'b1, FIXED,   1'b0, 1'b0);
        dir_rows[8]  = row(REQ_PIXEL,   8,   7, 1'b1, 1'b1, FIXED,   1'b0, 1'b0);
        dir_rows[9]  = row(REQ_PIXEL, 255, 255, 1'b0, 1'b1, FIXED,   1'b0, 1'b0);
        dir_rows[10] = row(REQ_PIXEL,   0,   0, 1'b1, 1'b1, FIXED,   1'b0, 1'b1);
        dir_rows[11] = row(REQ_QUERY,   0,   0, 1'b0, 1'b0, PREDICT, 1'b0, 1'b0);
        dir_rows[12] = row(REQ_QUERY, 255, 255, 1'b0, 1'b0, PREDICT, 1'b0, 1'b0);
        dir_rows[13] = row(REQ_QUERY, 128, 128, 1'b0, 1'b0, PREDICT, 1'b0, 1'b0);
        dir_rows[14] = row(REQ_QUERY,   8, 255, 1'b1, 1'b0, PREDICT, 1'b0, 1'b0);
        dir_rows[15] = row(REQ_QUERY, 255, 100, 1'b0, 1'b1, PREDICT, 1'b0, 1'b0);
        dir_rows[16] = row(REQ_PIXEL, 255,   0, 1'b0, 1'b1, FIXED,   1'b0, 1'b1);
        dir_rows[17] = row(REQ_PIXEL,   0, 255, 1'b0, 1'b1, FIXED,   1'b0, 1'b1);
        dir_rows[18] = row(REQ_PIXEL, 128,  64, 1'b0, 1'b1, FIXED,   1'b0, 1'b1);
        dir_rows[19] = row(REQ_PIXEL,  33, 170, 1'b0, 1'b1, FIXED,   1'b0, 1'b1);
        dir_rows[20] = row(REQ_PIXEL, 250,   5, 1'b0, 1'b1, FIXED,   1'b0, 1'b1);
        dir_rows[21] = row(REQ_QUERY, 200,  45, 1'b0, 1'b0, FIXED,   1'b1, 1'b1);
        dir_rows[22] = row(REQ_QUERY, 255,   0, 1'b1, 1'b1, FIXED,   1'b1, 1'b1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // first beats simply wait out the clearing pass behind pix_stall
        for (i = 0; i < DIR_N; i++)
            send_item(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].res);

        // threshold at the floor: every bin passes
        write_threshold(7'd0);
        random_stretch(250, 60, 190);

        // threshold at a hundred, with a long receiver hold-off halfway
        write_threshold(7'd100);
        random_stretch(120, 90, 160);
        hold_reqs <= hold_reqs + 1;
        random_stretch(130, 90, 160);

        // above a hundred: only bins against an empty maximum pass
        write_threshold(7'd127);
        random_stretch(100, 140, 110);
        drain();
        random_stretch(100, 140, 110);

        // a random setting, run with no idling on either side
        write_threshold(THR_W'($urandom_range(1, 99)));
        quiet <= 1'b1;
        random_stretch(300, 30, 220);
        quiet <= 1'b0;

        write_threshold(THR_RESET);
        random_stretch(300, 110, 120);

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d pixel beats, %0d query beats, %0d frame closes, %0d results",
                 pixels_sent, queries_sent, frames_closed, verdicts_seen);
        $display("thresholds 0, 100, 127, a random one and 30; long hold-off, drain, no-idle run");
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver side: checks result beats and drives res_stall
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int       hold_left;
        int       holds_done;
        uvh_res_t want;
        hold_left  = 0;
        holds_done = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result beat with nothing expected: is_green %b field_formed %b",
                           res_data.is_green, res_data.field_formed);
                    mismatches++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    verdicts_seen++;
                    if (res_data.is_green !== want.is_green)
                    begin
                        $error("is_green: expected %b, got %b", want.is_green,
                               res_data.is_green);
                        mismatches++;
                    end
                    if (res_data.field_formed !== want.field_formed)
                    begin
                        $error("field_formed: expected %b, got %b", want.field_formed,
                               res_data.field_formed);
                        mismatches++;
                    end
                end
            end
            // a requested hold-off lets the learner fill and stall its input
            if (hold_left == 0 && hold_reqs != holds_done)
            begin
                hold_left = HOLD_LEN;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
                res_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
